### sv/bwo_pkg.sv
package bwo_pkg;

    // default limits of the block
    localparam int BWO_MAX_COLS   = 1024;
    localparam int BWO_MAX_ROWS   = 1024;
    localparam int BWO_MAX_WINDOW = 16;

    // fixed field widths
    localparam int DIM_W  = 11;
    localparam int WIN_W  = 5;
    localparam int POS_W  = 10;
    localparam int CFG_IW = 2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_WINDOW_SIZE  = 2'd2;

    // register reset values
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [WIN_W-1:0] RST_WINDOW_SIZE  = 5'd1;

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // control towards the column counter store
    typedef struct packed {
        logic vld;      // item issued this cycle
        logic obst;     // obstacle flag of the item
        logic clear;    // item closes the frame
    } t_col_req;

    // one result item
    typedef struct packed {
        logic             blocked;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             row_end;
        logic             frame_end;
    } t_result;

endpackage

### sv/bwo_colmem.sv
module bwo_colmem import bwo_pkg::*; #(
    parameter int MAX_COLS   = BWO_MAX_COLS,
    parameter int MAX_WINDOW = BWO_MAX_WINDOW
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  t_col_req                                       i_req,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] i_col,
    output logic [$clog2(MAX_WINDOW + 1)-1:0]              o_cnt
);

    localparam int ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int FillW = $clog2(MAX_COLS + 1);
    localparam int CntW  = $clog2(MAX_WINDOW + 1);
    localparam logic [CntW-1:0] Sat = CntW'(MAX_WINDOW);

    logic [CntW-1:0]  r_mem [MAX_COLS];
    logic [CntW-1:0]  r_q;
    logic             r_vld;
    logic             r_obst;
    logic             r_clear;
    logic [ColW-1:0]  r_col;
    logic [FillW-1:0] r_fill;
    logic [FillW-1:0] n_fill;
    logic             r_fwd_vld;
    logic [ColW-1:0]  r_fwd_col;
    logic [CntW-1:0]  r_fwd_cnt;
    logic [CntW-1:0]  base;
    logic [CntW-1:0]  cnt_new;
    logic [FillW-1:0] col_next;

    // counter memory: read at issue, write back in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_req.vld) begin
            r_q <= r_mem[i_col];
        end
        if (r_vld) begin
            r_mem[r_col] <= cnt_new;
        end
    end

    // second stage item details
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_req.vld;
        end
        if (i_req.vld) begin
            r_obst  <= i_req.obst;
            r_clear <= i_req.clear;
            r_col   <= i_col;
        end
    end

    // counter update; columns beyond the fill mark count as saturated
    always_comb begin
        if (r_fwd_vld && (r_fwd_col == r_col)) begin
            base = r_fwd_cnt;
        end else if (FillW'(r_col) < r_fill) begin
            base = r_q;
        end else begin
            base = Sat;
        end
        if (r_obst) begin
            cnt_new = '0;
        end else if (base < Sat) begin
            cnt_new = base + CntW'(1);
        end else begin
            cnt_new = base;
        end
    end

    // fill mark: every row writes a prefix of columns
    always_comb begin
        col_next = FillW'(r_col) + FillW'(1);
        n_fill   = r_fill;
        if (r_vld) begin
            if (r_clear) begin
                n_fill = '0;
            end else if (col_next > r_fill) begin
                n_fill = col_next;
            end
        end
    end

    // fill mark and forwarding of the last write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (r_vld) begin
                r_fwd_vld <= !r_clear;
            end
        end
        if (r_vld) begin
            r_fwd_col <= r_col;
            r_fwd_cnt <= cnt_new;
        end
    end

    assign o_cnt = cnt_new;

endmodule

### sv/bwo_out_fifo.sv
module bwo_out_fifo import bwo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_result            i_item,
    input  logic               i_stall,
    output logic               o_valid,
    output t_result            o_item,
    output logic [FIFO_CW-1:0] o_count
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0] r_wr_ptr;
    logic [FIFO_PW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic               pop;

    assign pop = (r_count != '0) && !i_stall;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PW'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (!i_push && pop) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

### sv/binary_window_occupancy.sv
// a result item passes the stage two registers and is then pushed into the result queue,
//   from which it can be taken
// throughput: one cell per cycle while the input is not stalled, set by the column counter
//   memory's read at acceptance and write back in the next cycle
// input stalls once three results are queued or on their way
// reset: synchronous, active low; positions clear, counters read as saturated
//   through a fill mark, so no clearing pass is needed
module binary_window_occupancy import bwo_pkg::*; #(
    parameter int MAX_COLS   = BWO_MAX_COLS,
    parameter int MAX_ROWS   = BWO_MAX_ROWS,
    parameter int MAX_WINDOW = BWO_MAX_WINDOW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_cell_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_blocked,
    output logic [POS_W-1:0]  o_out_row,
    output logic [POS_W-1:0]  o_out_col,
    output logic              o_row_end,
    output logic              o_frame_end,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]  i_cfg_data
);

    localparam int ColW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RowW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ColCntW = $clog2(MAX_COLS + 1);
    localparam int RowCntW = $clog2(MAX_ROWS + 1);
    localparam int CntW    = $clog2(MAX_WINDOW + 1);
    localparam logic [CntW-1:0] Sat = CntW'(MAX_WINDOW);

    logic [DIM_W-1:0]   r_frame_width;
    logic [DIM_W-1:0]   r_frame_height;
    logic [WIN_W-1:0]   r_window_size;
    logic [ColCntW-1:0] w_eff;
    logic [RowCntW-1:0] h_eff;
    logic [CntW-1:0]    ws_eff;

    logic [ColW-1:0]    r_col;
    logic [RowW-1:0]    r_row;
    logic               in_acc;
    logic               last_col;
    logic               last_row;
    logic               emit;
    logic [31:0]        row_diff;
    logic [31:0]        col_diff;
    t_col_req           col_req;

    logic               r_s2_vld;
    logic               r_s2_emit;
    logic               r_s2_first_col;
    logic               r_s2_last_col;
    logic               r_s2_frame_last;
    logic [POS_W-1:0]   r_s2_out_row;
    logic [POS_W-1:0]   r_s2_out_col;
    logic [CntW-1:0]    r_hz;
    logic [CntW-1:0]    hz_prev;
    logic [CntW-1:0]    hz_new;
    logic [CntW-1:0]    col_cnt;
    t_result            res;
    t_result            out_item;
    logic [FIFO_CW-1:0] fifo_count;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_window_size  <= RST_WINDOW_SIZE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_WINDOW_SIZE:  r_window_size  <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes: zero reads as one, large values clamp to the limit
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = ColCntW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_COLS)) begin
            w_eff = ColCntW'(MAX_COLS);
        end else begin
            w_eff = ColCntW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = RowCntW'(1);
        end else if (32'(r_frame_height) > 32'(MAX_ROWS)) begin
            h_eff = RowCntW'(MAX_ROWS);
        end else begin
            h_eff = RowCntW'(r_frame_height);
        end
        if (r_window_size == '0) begin
            ws_eff = CntW'(1);
        end else if (32'(r_window_size) > 32'(MAX_WINDOW)) begin
            ws_eff = Sat;
        end else begin
            ws_eff = CntW'(r_window_size);
        end
    end

    // stage one: position of the item and window origin
    assign o_in_stall = (fifo_count + FIFO_CW'(r_s2_vld)) >= FIFO_CW'(FIFO_DEPTH - 1);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        last_col = (32'(r_col) + 32'd1) >= 32'(w_eff);
        last_row = (32'(r_row) + 32'd1) >= 32'(h_eff);
        emit     = ((32'(r_row) + 32'd1) >= 32'(ws_eff))
                && ((32'(r_col) + 32'd1) >= 32'(ws_eff));
        row_diff = 32'(r_row) + 32'd1 - 32'(ws_eff);
        col_diff = 32'(r_col) + 32'd1 - 32'(ws_eff);
        col_req.vld   = in_acc;
        col_req.obst  = i_cell_req;
        col_req.clear = last_col && last_row;
    end

    // raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (last_col) begin
                r_col <= '0;
                if (last_row) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + RowW'(1);
                end
            end else begin
                r_col <= r_col + ColW'(1);
            end
        end
    end

    // per-column distance counters
    bwo_colmem #(
        .MAX_COLS   (MAX_COLS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_colmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (col_req),
        .i_col   (r_col),
        .o_cnt   (col_cnt)
    );

    // stage two item details
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= in_acc;
        end
        if (in_acc) begin
            r_s2_emit       <= emit;
            r_s2_first_col  <= (r_col == '0);
            r_s2_last_col   <= last_col;
            r_s2_frame_last <= last_col && last_row;
            r_s2_out_row    <= row_diff[POS_W-1:0];
            r_s2_out_col    <= col_diff[POS_W-1:0];
        end
    end

    // horizontal distance since a column with a recent obstacle
    always_comb begin
        hz_prev = r_s2_first_col ? Sat : r_hz;
        if (col_cnt < ws_eff) begin
            hz_new = '0;
        end else if (hz_prev < Sat) begin
            hz_new = hz_prev + CntW'(1);
        end else begin
            hz_new = hz_prev;
        end
        res.blocked   = hz_new < ws_eff;
        res.out_row   = r_s2_out_row;
        res.out_col   = r_s2_out_col;
        res.row_end   = r_s2_last_col;
        res.frame_end = r_s2_frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hz <= Sat;
        end else if (r_s2_vld) begin
            r_hz <= r_s2_frame_last ? Sat : hz_new;
        end
    end

    // result queue
    bwo_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_vld && r_s2_emit),
        .i_item  (res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_item  (out_item),
        .o_count (fifo_count)
    );

    assign o_blocked   = out_item.blocked;
    assign o_out_row   = out_item.out_row;
    assign o_out_col   = out_item.out_col;
    assign o_row_end   = out_item.row_end;
    assign o_frame_end = out_item.frame_end;

endmodule

### sv/bwo_checker.sv
module bwo_checker import bwo_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_blocked,
    input logic [POS_W-1:0]  o_out_row,
    input logic [POS_W-1:0]  o_out_col,
    input logic              o_row_end,
    input logic              o_frame_end
);

    // no result item right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    // a fresh result needs an accepted item that went through stage two and the result queue
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result appeared without an accepted item");

    // the frame closes on a row end
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> o_row_end)
        else $error("frame end without row end");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_blocked)
            && $stable(o_out_row) && $stable(o_out_col)))
        else $error("stalled result changed");

endmodule

bind binary_window_occupancy bwo_checker u_bwo_checker (.*);

### verif/binary_window_occupancy_test.sv
module binary_window_occupancy_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bwo_pkg::*;

    localparam int STALL_LIMIT = 2000;

    // block ports
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_cell_req = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_blocked;
    logic [POS_W-1:0]  o_out_row;
    logic [POS_W-1:0]  o_out_col;
    logic              o_row_end;
    logic              o_frame_end;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0]  i_cfg_data = '0;

    // stimulus and scoreboard
    logic        cells_pending[$];
    t_result     occupancy_due[$];
    t_result     want;
    logic        cell_taken = 1'b0;
    logic        quiet_phase = 1'b0;
    logic        progress;
    int unsigned hold_in = 0;
    int unsigned stall_run = 0;
    int unsigned stall_len;
    int unsigned idle_cycles = 0;
    int unsigned cells_queued = 0;
    int unsigned cells_taken = 0;
    int unsigned results_seen = 0;
    int unsigned frame_settings = 0;
    int unsigned mismatches = 0;

    // predicted register and counter state
    logic [DIM_W-1:0] grid_width = RST_FRAME_WIDTH;
    logic [DIM_W-1:0] grid_height = RST_FRAME_HEIGHT;
    logic [WIN_W-1:0] square_side = RST_WINDOW_SIZE;
    logic [WIN_W-1:0] rows_clear[BWO_MAX_COLS];
    logic [WIN_W-1:0] cols_clear = WIN_W'(BWO_MAX_WINDOW);
    logic [POS_W-1:0] cur_row = '0;
    logic [POS_W-1:0] cur_col = '0;

    binary_window_occupancy u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cell_req  (i_cell_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_blocked   (o_blocked),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // zero reads as one, oversize clamps to the limit
    function automatic int unsigned fit_range(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // mostly short gaps, now and then a long one, none in a quiet phase
    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet_phase || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void apply_setting(input logic [CFG_IW-1:0] idx,
                                          input logic [DIM_W-1:0] val);
        case (idx)
            CFG_FRAME_WIDTH: begin
                grid_width = val;
            end
            CFG_FRAME_HEIGHT: begin
                grid_height = val;
            end
            CFG_WINDOW_SIZE: begin
                square_side = val[WIN_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // dilation step: update column and horizontal distances, queue the window result
    function automatic void predict_occupancy(input logic obst);
        int unsigned w, h, ws, r, c, cnt, hz;
        logic last_col, last_row;
        t_result res;
        w  = fit_range(grid_width, BWO_MAX_COLS);
        h  = fit_range(grid_height, BWO_MAX_ROWS);
        ws = fit_range(square_side, BWO_MAX_WINDOW);
        r  = cur_row;
        c  = cur_col;

        cnt = rows_clear[c];
        if (obst) cnt = 0;
        else if (cnt < BWO_MAX_WINDOW) cnt++;
        rows_clear[c] = WIN_W'(cnt);

        // horizontal count restarts saturated at each row start
        hz = (c == 0) ? BWO_MAX_WINDOW : cols_clear;
        if (cnt < ws) hz = 0;
        else if (hz < BWO_MAX_WINDOW) hz++;
        cols_clear = WIN_W'(hz);

        last_col = c >= w - 1;
        last_row = r >= h - 1;

        if (r + 1 >= ws && c + 1 >= ws) begin
            res.blocked   = hz < ws;
            res.out_row   = POS_W'(r + 1 - ws);
            res.out_col   = POS_W'(c + 1 - ws);
            res.row_end   = last_col;
            res.frame_end = last_col && last_row;
            occupancy_due.insert(occupancy_due.size(), res);
        end

        // advance the raster position, clearing all distances at frame end
        if (last_col) begin
            cur_col = '0;
            if (last_row) begin
                cur_row = '0;
                foreach (rows_clear[i]) rows_clear[i] = WIN_W'(BWO_MAX_WINDOW);
                cols_clear = WIN_W'(BWO_MAX_WINDOW);
            end else begin
                cur_row = POS_W'(r + 1);
            end
        end else begin
            cur_col = POS_W'(c + 1);
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        if (mismatches < 40)
            $display("%0t ns  %s: got %0d, expected %0d", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    task automatic feed_cell(input logic obst);
        cells_pending.insert(cells_pending.size(), obst);
        cells_queued++;
    endtask

    // cells taken lsb first
    task automatic load_cells(input logic [15:0] bits, input int n);
        for (int i = 0; i < n; i++) feed_cell(bits[i]);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic [DIM_W-1:0] ws);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_WINDOW_SIZE, ws);
        frame_settings++;
    endtask

    // wait for every cell taken and every result back, then let the pipe empty
    task automatic settle();
        do @(negedge i_clk);
        while (cells_taken != cells_queued || occupancy_due.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    // cell driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || cell_taken)) begin
            if (hold_in != 0) begin
                i_in_valid <= 1'b0;
                hold_in    <= hold_in - 1;
            end else if (cells_pending.size() != 0) begin
                i_cell_req <= cells_pending.pop_front();
                i_in_valid <= 1'b1;
                hold_in    <= draw_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result back-pressure in runs
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_len = draw_gap();
            if (stall_len == 0) begin
                i_out_stall <= 1'b0;
                stall_run   <= $urandom_range(0, 4);
            end else begin
                i_out_stall <= 1'b1;
                stall_run   <= stall_len - 1;
            end
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    // monitor, prediction and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                apply_setting(i_cfg_index, i_cfg_data);
                progress = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                predict_occupancy(i_cell_req);
                cells_taken++;
                progress = 1'b1;
            end
            cell_taken <= i_in_valid && !o_in_stall;

            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                progress = 1'b1;
                if (occupancy_due.size() == 0) begin
                    report_mismatch("result with none expected, blocked", o_blocked, 0);
                end else begin
                    want = occupancy_due.pop_front();
                    if (o_blocked !== want.blocked)
                        report_mismatch("blocked", o_blocked, want.blocked);
                    if (o_out_row !== want.out_row)
                        report_mismatch("out_row", o_out_row, want.out_row);
                    if (o_out_col !== want.out_col)
                        report_mismatch("out_col", o_out_col, want.out_col);
                    if (o_row_end !== want.row_end)
                        report_mismatch("row_end", o_row_end, want.row_end);
                    if (o_frame_end !== want.frame_end)
                        report_mismatch("frame_end", o_frame_end, want.frame_end);
                end
            end

            if (progress) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("no handshake for %0d cycles, %0d results outstanding",
                         idle_cycles, occupancy_due.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial begin
        int unsigned roll, w_data, h_data, ws_val, w_eff, h_eff, n, pct;
        int unsigned random_cells;
        random_cells = 0;
        foreach (rows_clear[i]) rows_clear[i] = WIN_W'(BWO_MAX_WINDOW);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register reset values: wide frame, window of one
        load_cells(16'b001, 3);
        settle();
        // 3x3 frame, window 2, single obstacle in the centre, through frame end
        set_frame(3, 3, 2);
        load_cells(16'h0010, 9);
        settle();
        // zero sizes act as one: every cell closes a frame
        set_frame(0, 0, 0);
        load_cells(16'b01, 2);
        settle();
        // all ones: sizes clamp to the limits, window above the limit
        set_frame(11'h7FF, 11'h7FF, 11'h7FF);
        load_cells(16'b101, 3);
        settle();
        // window larger than frame, narrower width wraps the current column
        set_frame(2, 2, 3);
        load_cells(16'b1111, 4);

        // random frames of mostly small size
        while (random_cells < 200) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) w_data = 0;
            else if (roll < 10) w_data = $urandom_range(1025, 2047);
            else if (roll < 80) w_data = $urandom_range(1, 12);
            else w_data = $urandom_range(13, 40);
            roll = $urandom_range(0, 99);
            if (roll < 6) h_data = 0;
            else if (roll < 9) h_data = $urandom_range(1025, 2047);
            else h_data = $urandom_range(1, 10);
            roll = $urandom_range(0, 99);
            if (roll < 5) ws_val = 0;
            else if (roll < 10) ws_val = $urandom_range(17, 31);
            else if (roll < 75) ws_val = $urandom_range(1, 4);
            else ws_val = $urandom_range(5, 16);
            case ($urandom_range(0, 3))
                0: pct = 3;
                1: pct = 20;
                2: pct = 50;
                default: pct = 85;
            endcase
            w_eff = fit_range(w_data, BWO_MAX_COLS);
            h_eff = fit_range(h_data, BWO_MAX_ROWS);
            n = w_eff * h_eff * $urandom_range(1, 2) + $urandom_range(0, w_eff);
            if (n > 60) n = 60;

            settle();
            // upper data bits of the window write are ignored
            set_frame(DIM_W'(w_data), DIM_W'(h_data),
                      {6'($urandom), WIN_W'(ws_val)});
            quiet_phase = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < n; i++) feed_cell($urandom_range(0, 99) < pct);
            random_cells += n;
        end

        // large window over a sparse frame
        settle();
        set_frame(14, 13, 12);
        quiet_phase = 1'b0;
        for (int i = 0; i < 182; i++) feed_cell($urandom_range(0, 99) < 2);

        settle();
        repeat (8) @(posedge i_clk);
        $display("checked %0d results from %0d cells over %0d frame and window settings",
                 results_seen, cells_taken, frame_settings);
        $display("frames from one cell up to the clamped limits, windows from 1 to beyond 16");
        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
sv/bwo_pkg.sv
sv/bwo_colmem.sv
sv/bwo_out_fifo.sv
sv/binary_window_occupancy.sv
sv/bwo_checker.sv
verif/binary_window_occupancy_test.sv
